// ----- rtl/gosd_pkg.sv -----
// Shared codes, constants and types for the graphics order stream deframer.
package gosd_pkg;

   // Parser phase codes
   localparam logic [2:0] PH_ID    = 3'd0;
   localparam logic [2:0] PH_LEN   = 3'd1;
   localparam logic [2:0] PH_BODY  = 3'd2;
   localparam logic [2:0] PH_OPC   = 3'd3;
   localparam logic [2:0] PH_LENB  = 3'd4;
   localparam logic [2:0] PH_PAY   = 3'd5;
   localparam logic [2:0] PH_DEAD  = 3'd6;
   localparam logic [2:0] PH_SMALL = 3'd7;

   // Byte kind codes
   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_OPCODE  = 3'd1;
   localparam logic [2:0] KIND_LENGTH  = 3'd2;
   localparam logic [2:0] KIND_PAYLOAD = 3'd3;
   localparam logic [2:0] KIND_IGNORED = 3'd4;

   // Fault codes
   localparam logic [2:0] FLT_NONE      = 3'd0;
   localparam logic [2:0] FLT_BAD_ID    = 3'd1;
   localparam logic [2:0] FLT_BAD_LEN   = 3'd2;
   localparam logic [2:0] FLT_NO_EXTENT = 3'd3;
   localparam logic [2:0] FLT_SHORT_HDR = 3'd4;
   localparam logic [2:0] FLT_CUT_HEAD  = 3'd5;
   localparam logic [2:0] FLT_CUT_PAY   = 3'd6;

   // Header and order constants
   localparam logic [7:0]  ASSET_ID        = 8'h01;
   localparam logic [7:0]  LOW_NIBBLE_MASK = 8'h0f;
   localparam logic [7:0]  SHORT_LOW_MIN   = 8'h08;
   localparam logic [7:0]  MIN_HDR_LEN     = 8'd2;
   localparam logic [7:0]  EXTENT_LEN_WIDE = 8'd18;
   localparam logic [7:0]  EXTENT_LEN_NARROW = 8'd10;
   localparam logic [15:0] COORD_NARROW    = 16'd2;

   typedef struct packed {
      logic [2:0]  phase;
      logic [7:0]  header_left;
      logic [7:0]  header_seen;
      logic [15:0] coord_kind;
      logic [7:0]  held_opcode;
      logic [7:0]  payload_left;
      logic [7:0]  payload_count;
      logic [2:0]  fault_latch;
   } gosd_state_type;

   typedef struct packed {
      logic [2:0] byte_kind;
      logic [7:0] record_opcode;
      logic [7:0] payload_position;
      logic       record_done;
      logic       wide_coordinates;
      logic [2:0] fault;
   } gosd_rsp_type;

endpackage

// ----- rtl/gosd_if.sv -----
// Valid/ready channel interfaces for the deframer's byte input and labeled output.
interface gosd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       asset_end;

   modport source (output valid, output data_byte, output asset_end, input ready);
   modport sink   (input valid, input data_byte, input asset_end, output ready);
endinterface

interface gosd_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] byte_kind;
   logic [7:0] record_opcode;
   logic [7:0] payload_position;
   logic       record_done;
   logic       wide_coordinates;
   logic [2:0] fault;

   modport source (output valid, output byte_kind, output record_opcode,
                   output payload_position, output record_done,
                   output wide_coordinates, output fault, input ready);
   modport sink   (input valid, input byte_kind, input record_opcode,
                   input payload_position, input record_done,
                   input wide_coordinates, input fault, output ready);
endinterface

// ----- rtl/gosd_step.sv -----
// Per-byte parser step: next parser state and the label of the current byte.
module gosd_step (
   input  gosd_pkg::gosd_state_type cur,
   input  logic [7:0]               data_byte,
   input  logic                     asset_end,
   output gosd_pkg::gosd_state_type nxt,
   output gosd_pkg::gosd_rsp_type   res
);
   import gosd_pkg::*;

   logic [7:0]  seen_inc;
   logic [7:0]  left_dec;
   logic [7:0]  pay_dec;
   logic [15:0] coord_new;
   logic        wide_cur;
   logic        wide_new;
   logic        extent_ok;
   logic        short_form;
   logic        dead;
   logic [2:0]  flt;

   // Counter updates, header field capture, and the extent and short-form checks
   always_comb begin
      seen_inc = (cur.header_seen != 8'hff) ? cur.header_seen + 8'd1 : cur.header_seen;
      left_dec = (cur.header_left != 8'd0) ? cur.header_left - 8'd1 : 8'd0;
      pay_dec  = (cur.payload_left != 8'd0) ? cur.payload_left - 8'd1 : 8'd0;
      if (seen_inc == 8'd1) begin
         coord_new = {data_byte, 8'h00};
      end else if (seen_inc == 8'd2) begin
         coord_new = cur.coord_kind | {8'h00, data_byte};
      end else begin
         coord_new = cur.coord_kind;
      end
      wide_cur  = (cur.coord_kind != COORD_NARROW);
      wide_new  = (coord_new != COORD_NARROW);
      extent_ok = ((coord_new == COORD_NARROW) && (seen_inc >= EXTENT_LEN_NARROW)) ||
                  (seen_inc >= EXTENT_LEN_WIDE);
      // high nibble below 8 and low nibble 8 or more
      short_form = !data_byte[7] &&
                   ((data_byte & LOW_NIBBLE_MASK) >= SHORT_LOW_MIN);
   end

   // Phase decode
   always_comb begin
      nxt  = cur;
      res  = '0;
      dead = 1'b0;
      flt  = FLT_NONE;
      case (cur.phase)
         PH_ID: begin
            if (data_byte != ASSET_ID) begin
               flt = FLT_BAD_ID;
            end else if (asset_end) begin
               flt = FLT_SHORT_HDR;
            end else begin
               nxt.phase = PH_LEN;
            end
         end
         PH_LEN: begin
            if (asset_end) begin
               flt = FLT_SHORT_HDR;
            end else begin
               nxt.header_left = data_byte;
               nxt.header_seen = 8'd0;
               nxt.phase       = (data_byte < MIN_HDR_LEN) ? PH_SMALL : PH_BODY;
            end
         end
         PH_SMALL: begin
            nxt.header_seen = seen_inc;
            nxt.coord_kind  = coord_new;
            if (seen_inc >= 8'd2) begin
               flt = FLT_BAD_LEN;
            end else if (asset_end) begin
               flt = FLT_SHORT_HDR;
            end
         end
         PH_BODY: begin
            nxt.header_seen = seen_inc;
            nxt.coord_kind  = coord_new;
            nxt.header_left = left_dec;
            if (seen_inc >= 8'd2) begin
               res.wide_coordinates = wide_new;
            end
            if (left_dec == 8'd0) begin
               if (!extent_ok) begin
                  flt = FLT_NO_EXTENT;
               end else begin
                  nxt.phase = PH_OPC;
               end
            end else if (asset_end) begin
               flt = (seen_inc < 8'd2) ? FLT_SHORT_HDR : FLT_BAD_LEN;
            end
         end
         PH_OPC: begin
            res.byte_kind        = KIND_OPCODE;
            res.record_opcode    = data_byte;
            res.wide_coordinates = wide_cur;
            nxt.held_opcode      = data_byte;
            nxt.payload_count    = 8'd0;
            if (data_byte == 8'd0) begin
               res.record_done = 1'b1;
            end else if (short_form) begin
               nxt.payload_left = 8'd1;
               nxt.phase        = PH_PAY;
               if (asset_end) flt = FLT_CUT_PAY;
            end else begin
               nxt.phase = PH_LENB;
               if (asset_end) flt = FLT_CUT_HEAD;
            end
         end
         PH_LENB: begin
            res.byte_kind        = KIND_LENGTH;
            res.record_opcode    = cur.held_opcode;
            res.wide_coordinates = wide_cur;
            nxt.payload_left     = data_byte;
            if (data_byte == 8'd0) begin
               res.record_done = 1'b1;
               nxt.phase       = PH_OPC;
            end else begin
               nxt.phase = PH_PAY;
               if (asset_end) flt = FLT_CUT_PAY;
            end
         end
         PH_PAY: begin
            res.byte_kind        = KIND_PAYLOAD;
            res.record_opcode    = cur.held_opcode;
            res.wide_coordinates = wide_cur;
            res.payload_position = cur.payload_count;
            nxt.payload_count    = cur.payload_count + 8'd1;
            nxt.payload_left     = pay_dec;
            if (pay_dec == 8'd0) begin
               res.record_done = 1'b1;
               nxt.phase       = PH_OPC;
            end else if (asset_end) begin
               flt = FLT_CUT_PAY;
            end
         end
         default: begin
            dead          = 1'b1;
            res.byte_kind = KIND_IGNORED;
            flt           = cur.fault_latch;
         end
      endcase

      // Latch a new fault and park the parser
      if (!dead && (flt != FLT_NONE)) begin
         nxt.fault_latch = flt;
         nxt.phase       = PH_DEAD;
      end
      // Start over after the last byte of an asset
      if (asset_end) begin
         nxt = '0;
      end
      res.fault = flt;
   end

endmodule

// ----- rtl/gosd_outq.sv -----
// Two-entry result buffer: output register plus skid entry.
module gosd_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gosd_pkg::gosd_rsp_type push_data,
   output logic                   space,
   output logic                   out_valid,
   input  logic                   out_ready,
   output gosd_pkg::gosd_rsp_type out_data
);
   import gosd_pkg::*;

   gosd_rsp_type head_ff;
   gosd_rsp_type head_in;
   gosd_rsp_type skid_ff;
   gosd_rsp_type skid_in;
   logic         head_valid_ff;
   logic         head_valid_in;
   logic         skid_valid_ff;
   logic         skid_valid_in;
   logic         pop;

   assign pop       = head_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;

   // Advance the head from the skid entry, or load the new transaction into the head or skid entry
   always_comb begin
      head_in       = head_ff;
      skid_in       = skid_ff;
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            head_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            head_in       = push_data;
            head_valid_in = push;
         end
      end else if (push) begin
         if (!head_valid_ff) begin
            head_in       = push_data;
            head_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   // The skid entry is only ever filled behind a full head
   a_skid_behind_head: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> head_valid_ff)
      else $error("skid entry valid with empty head");

   // A transaction is never pushed into a full buffer
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && skid_valid_ff))
      else $error("push into full result buffer");

   // A stalled skid entry moves to the head once the head is taken
   a_skid_advances: assert property (@(posedge clock) disable iff (reset)
      (pop && skid_valid_ff) |=> (head_valid_ff && (head_ff == $past(skid_ff))))
      else $error("skid entry lost on head pop");

endmodule

// ----- rtl/graphics_order_stream_deframer_top.sv -----
// Top level of the graphics order stream deframer.
// Accepts one asset byte per cycle while req_if.ready is high and returns one
// registered labeled result per byte, in order. The parser state updates in the
// same cycle the byte is accepted, so a byte can follow in every cycle; the
// results pass through a two-entry buffer (output register plus skid entry),
// so one more byte is taken while a result waits, and req_if.ready drops only
// when both entries are full. Sustained rate is one transaction per cycle while
// the result side keeps up. The parser returns to its reset state after every
// byte flagged as the end of an asset.
module graphics_order_stream_deframer_top (
   input  logic        clock,
   input  logic        reset,
   gosd_req_if.sink    req_if,
   gosd_rsp_if.source  rsp_if
);
   import gosd_pkg::*;

   gosd_state_type state_ff;
   gosd_state_type state_in;
   gosd_state_type step_nxt;
   gosd_rsp_type   step_res;
   gosd_rsp_type   rsp_data;
   logic           accept;
   logic           space;

   assign accept       = req_if.valid && space;
   assign req_if.ready = space;

   // Parser step
   gosd_step u_step (
      .cur       (state_ff),
      .data_byte (req_if.data_byte),
      .asset_end (req_if.asset_end),
      .nxt       (step_nxt),
      .res       (step_res)
   );

   // Hold state unless a transaction is taken
   assign state_in = accept ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   // Result buffer
   gosd_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (step_res),
      .space     (space),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_data  (rsp_data)
   );

   assign rsp_if.byte_kind        = rsp_data.byte_kind;
   assign rsp_if.record_opcode    = rsp_data.record_opcode;
   assign rsp_if.payload_position = rsp_data.payload_position;
   assign rsp_if.record_done      = rsp_data.record_done;
   assign rsp_if.wide_coordinates = rsp_data.wide_coordinates;
   assign rsp_if.fault            = rsp_data.fault;

   // A parked parser always holds a fault code
   a_dead_has_fault: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_DEAD) |-> (state_ff.fault_latch != FLT_NONE))
      else $error("parser parked without a fault code");

   // The last byte of an asset returns the parser to its reset state
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_if.asset_end) |=> (state_ff == '0))
      else $error("state not cleared after asset end");

   // Ignored bytes always carry a fault code
   a_ignored_faulted: assert property (@(posedge clock) disable iff (reset)
      (accept && (step_res.byte_kind == KIND_IGNORED)) |-> (step_res.fault != FLT_NONE))
      else $error("ignored byte without fault");

endmodule
